[sv/assert_macros.svh]
// Assertion macros used by the top level RTL file of the prime sieve engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge outside reset.
`define PSE_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define PSE_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

[sv/pse_pkg.sv]
// Types and constants shared by the prime sieve engine modules.
`default_nettype none

package pse_pkg;

  // Width of numbers, limits and counts.
  localparam int unsigned LIM_W = 20;
  // Width of the marking pointer, which may step one prime past the limit.
  localparam int unsigned M_W = LIM_W + 1;
  // Bits per row of the composite bitmap and the shift that selects a row.
  localparam int unsigned ROW_BITS = 32;
  localparam int unsigned ROW_SH = 5;
  // Limit after reset.
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(10);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_EMIT
  } pse_state_e;

  typedef struct packed {
    logic [LIM_W-1:0] number;
    logic             is_prime;
    logic [LIM_W-1:0] prime_count;
    logic             last;
  } pse_res_t;

endpackage

`default_nettype wire

[sv/prime_sieve_engine.sv]
// Top level of the prime sieve engine: limit register, result register, checks.
// Reset runs a clearing sweep that writes all ceil(MAX_NUMBERS/32) rows; a restart holds the input
// through the same sweep. A non-prime number, or a prime n with 2n above the limit, passes through
// the check and emit states to the result register before the next input transfer is taken.
// A prime n with 2n <= limit first marks its multiples up to the limit: one read and one write
// of the bitmap memory port for each multiple marked. An advance past the end gives no result.
`default_nettype none
`include "assert_macros.svh"

module prime_sieve_engine import pse_pkg::*; #(
  parameter int unsigned MAX_NUMBERS = 1048576
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [LIM_W-1:0] cfg_upper_limit_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             restart_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [LIM_W-1:0]      number_o,
  output logic                  is_prime_o,
  output logic [LIM_W-1:0]      prime_count_o,
  output logic                  last_o
);

  // The composite bitmap is held in rows of ROW_BITS bits, so the clearing
  // sweep writes one whole row per cycle.
  localparam int unsigned ROWS   = (MAX_NUMBERS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // The effective limit is the written limit capped at the last bitmap entry.
  // The compare runs at the wider of the two widths.
  localparam int unsigned NUM_W = $clog2(MAX_NUMBERS);
  localparam int unsigned CMP_W = (NUM_W > LIM_W) ? NUM_W : LIM_W;
  localparam logic [CMP_W-1:0] CAP = CMP_W'(MAX_NUMBERS - 1);

  logic [LIM_W-1:0] lim_q, lim_d;

  logic              core_res_valid;
  logic              core_res_ready;
  pse_res_t          core_res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ROW_BITS-1:0] mem_rdata;

  logic     out_valid_q, out_valid_d;
  pse_res_t out_res_q;
  logic     res_take;

  // Limit register. The user must write it only while the engine is idle; the block does
  // not enforce this. The port never pushes back, and the cap is applied once at the write.
  assign cfg_ready_o = 1'b1;
  assign lim_d = (CMP_W'(cfg_upper_limit_i) > CAP) ? LIM_W'(CAP) : cfg_upper_limit_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lim_q <= lim_d;
    end
  end

  // The sequencer owns the pointer, the count and the marking walk; it
  // drives the single read and single write port of the bitmap.
  pse_core #(
    .ROWS (ROWS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim_q),
    .in_valid_i  (in_valid_i),
    .restart_i   (restart_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (core_res_valid),
    .res_ready_i (core_res_ready),
    .res_o       (core_res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pse_bitmap #(
    .ROWS (ROWS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result register. It parts the sequencer from the output channel, so the
  // engine can take the next input transfer while a result is still stalled.
  // A new result moves in when the register is empty or being drained.
  assign core_res_ready = !out_valid_q || !out_stall_i;
  assign res_take       = core_res_valid && core_res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign number_o      = out_res_q.number;
  assign is_prime_o    = out_res_q.is_prime;
  assign prime_count_o = out_res_q.prime_count;
  assign last_o        = out_res_q.last;

  // The sequencer offers a result only while it holds off new input.
  `PSE_ASSERT(a_res_while_busy, !core_res_valid || in_stall_o, "result offered while idle")
  // A restart transfer never produces a result in the following cycle.
  `PSE_ASSERT_NEXT(a_restart_quiet, in_valid_i && !in_stall_o && restart_i, !core_res_valid,
                   "restart produced a result")
  // The effective limit always stays inside the bitmap.
  `PSE_ASSERT(a_lim_in_map, CMP_W'(lim_q) <= CAP, "limit beyond bitmap")
  // Primes are distinct numbers of at least two, so the count never exceeds the number.
  `PSE_ASSERT(a_count_bound, !out_valid_o || (prime_count_o <= number_o),
              "prime count exceeds number")
  // Zero and one are never reported as prime.
  `PSE_ASSERT(a_small_not_prime, !out_valid_o || !is_prime_o || (number_o >= LIM_W'(2)),
              "number below two reported prime")

endmodule

`default_nettype wire

[sv/pse_bitmap.sv]
// Composite bitmap memory: one write port and one registered read port.
`default_nettype none

module pse_bitmap import pse_pkg::*; #(
  parameter int unsigned ROWS = 32768
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] waddr_i,
  input  wire logic [ROW_BITS-1:0]                   wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] raddr_i,
  output logic      [ROW_BITS-1:0]                   rdata_o
);

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/pse_core.sv]
// Sieve sequencer: clearing sweep, number check and the marking walk.
`default_nettype none

module pse_core import pse_pkg::*; #(
  parameter int unsigned ROWS = 32768
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [LIM_W-1:0]                      lim_i,
  input  wire logic                                  in_valid_i,
  input  wire logic                                  restart_i,
  output logic                                       in_stall_o,
  output logic                                       res_valid_o,
  input  wire logic                                  res_ready_i,
  output pse_res_t                                   res_o,
  output logic                                       mem_we_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] mem_waddr_o,
  output logic [ROW_BITS-1:0]                        mem_wdata_o,
  output logic                                       mem_re_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] mem_raddr_o,
  input  wire logic [ROW_BITS-1:0]                   mem_rdata_i
);

  localparam int unsigned ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(ROWS - 1);

  pse_state_e state_q, state_d;

  logic [LIM_W-1:0]  n_q;
  logic [LIM_W-1:0]  cnt_q;
  logic              fin_q;
  logic              prime_q;
  logic [M_W-1:0]    m_q;
  logic [ADDR_W-1:0] clr_q;

  logic              accept;
  logic              n_marked;
  logic              n_is_prime;
  logic [M_W-1:0]    two_n;
  logic [M_W-1:0]    m_sum;
  logic [M_W-1:0]    cand;
  logic              cand_ok;
  logic [ADDR_W-1:0] row_n;
  logic [ADDR_W-1:0] row_m;

  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign row_n      = ADDR_W'(n_q >> ROW_SH);
  assign row_m      = ADDR_W'(m_q >> ROW_SH);
  assign n_marked   = mem_rdata_i[n_q[ROW_SH-1:0]];
  assign n_is_prime = (n_q >= LIM_W'(2)) && !n_marked;
  assign two_n      = {n_q, 1'b0};

  // The one shared compare: the first multiple, 2n, during the check,
  // and the next multiple, from the add, during the walk.
  assign m_sum   = m_q + {1'b0, n_q};
  assign cand    = (state_q == ST_CHECK) ? two_n : m_sum;
  assign cand_ok = cand <= {1'b0, lim_i};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            state_d = ST_CLEAR;
          end else if (!fin_q && (n_q <= lim_i)) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        state_d = (n_is_prime && cand_ok) ? ST_MARK_RD : ST_EMIT;
      end
      ST_MARK_RD: begin
        state_d = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        state_d = cand_ok ? ST_MARK_RD : ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = row_m;
    mem_wdata_o = mem_rdata_i | (ROW_BITS'(1) << m_q[ROW_SH-1:0]);
    mem_re_o    = 1'b0;
    mem_raddr_o = row_m;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
      end
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        mem_re_o    = accept;
        mem_raddr_o = row_n;
      end
      ST_CHECK: begin
      end
      ST_MARK_RD: begin
        mem_re_o = 1'b1;
      end
      ST_MARK_WR: begin
        mem_we_o = 1'b1;
      end
      ST_EMIT: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      n_q     <= '0;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      prime_q <= 1'b0;
      m_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            if (restart_i) begin
              n_q   <= '0;
              cnt_q <= '0;
              fin_q <= 1'b0;
              clr_q <= '0;
            end else if (n_q > lim_i) begin
              fin_q <= 1'b1;
            end
          end
        end
        ST_CHECK: begin
          prime_q <= n_is_prime;
          m_q     <= two_n;
          if (n_is_prime) begin
            cnt_q <= cnt_q + LIM_W'(1);
          end
        end
        ST_MARK_RD: begin
        end
        ST_MARK_WR: begin
          m_q <= m_sum;
        end
        ST_EMIT: begin
          if (res_ready_i) begin
            if (n_q == lim_i) begin
              fin_q <= 1'b1;
            end else begin
              n_q <= n_q + LIM_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o.number      = n_q;
  assign res_o.is_prime    = prime_q;
  assign res_o.prime_count = cnt_q;
  assign res_o.last        = (n_q == lim_i);

endmodule

`default_nettype wire
